@@ rtl/core/kpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared constants and types for the keypad scanner with key debounce.
// ----------------------------------------------------------------------------
`default_nettype none

package kpsd_pkg;

    // Default geometry
    localparam int NUM_COLUMNS_DEF  = 4;
    localparam int NUM_ROWS_DEF     = 4;
    localparam int HISTORY_BITS_DEF = 8;

    // Upper bounds of the geometry, used to zero-extend the narrow fields
    localparam int MAX_ROWS         = 8;
    localparam int MAX_HISTORY_BITS = 16;

    // Field widths on the ports
    localparam int ROW_BITS_W     = 4;
    localparam int COL_DRIVE_W    = 4;
    localparam int KEY_W          = 4;
    localparam int PATTERN_W      = 8;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 16;
    localparam int OUT_FIELDS_W   = COL_DRIVE_W + 2 * (1 + KEY_W);
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    // Register reset values
    localparam logic [PATTERN_W-1:0] PRESS_PATTERN_RST   = 8'd1;
    localparam logic [PATTERN_W-1:0] RELEASE_PATTERN_RST = 8'd254;

    // Register index, taken from the word address
    localparam logic REG_IDX_PRESS   = 1'b0;
    localparam logic REG_IDX_RELEASE = 1'b1;

    // Result of one pattern search
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_match;

endpackage

`default_nettype wire

@@ rtl/core/kpsd_match.sv @@
// ----------------------------------------------------------------------------
// kpsd_match
// Compares every key history with a pattern; lowest matching key wins.
// ----------------------------------------------------------------------------
`default_nettype none

module kpsd_match #(
    parameter int NUM_KEYS     = kpsd_pkg::NUM_COLUMNS_DEF * kpsd_pkg::NUM_ROWS_DEF,
    parameter int HISTORY_BITS = kpsd_pkg::HISTORY_BITS_DEF
) (
    input  wire logic [HISTORY_BITS-1:0] i_hist [NUM_KEYS],
    input  wire logic [HISTORY_BITS-1:0] i_pattern,
    output kpsd_pkg::t_match             o_match
);

    // Walk downwards so the lowest index is the one left standing
    always_comb begin
        o_match = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (i_hist[k] == i_pattern) begin
                o_match.valid = 1'b1;
                o_match.key   = kpsd_pkg::KEY_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/keypad_scan_debounce.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_debounce
// Matrix keypad column scanner with a shift-register debounce per key.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one transfer per scan tick, tdata[3:0] holds the row lines
//    sampled while the current column was driven.
//  - Master stream: one transfer per scan tick: next column drive, and the
//    lowest key whose history equals the press / release pattern.
//  - APB: press pattern at 0x0, release pattern at 0x4 (low 8 bits). Write
//    only while the stream is quiet.
//  - Result: registered, presented in the cycle after the tick is accepted.
//  - Throughput: one tick per cycle while the sink is ready; history update,
//    compare and priority encode all sit between the key history registers
//    and the result register.
//  - Stall: the result register holds while the master side is stalled; a
//    new tick is taken in the same cycle the waiting result leaves, so
//    tready drops only while a result waits and the sink is not ready.
//  - Reset: histories cleared, column 0, patterns back to 1 / 254, master
//    stream empty.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_debounce #(
    parameter int NUM_COLUMNS  = kpsd_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS     = kpsd_pkg::NUM_ROWS_DEF,
    parameter int HISTORY_BITS = kpsd_pkg::HISTORY_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // slave stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: [3:0] row_bits, [7:4] zero
    input  wire logic [kpsd_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // master stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata: [3:0] column_drive, [4] press_valid, [8:5] press_key,
    //        [9] release_valid, [13:10] release_key, [15:14] zero
    output logic [kpsd_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // APB
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [kpsd_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  wire logic [kpsd_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic [kpsd_pkg::APB_DATA_W-1:0]        o_prdata,
    output logic                                   o_pready
);

    localparam int NUM_KEYS  = NUM_COLUMNS * NUM_ROWS;
    localparam int COL_W     = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int ROWS_EXT_W = kpsd_pkg::MAX_ROWS;
    localparam int PAT_EXT_W = kpsd_pkg::MAX_HISTORY_BITS;
    localparam int PAD_W     = kpsd_pkg::OUT_TDATA_W - kpsd_pkg::OUT_FIELDS_W;

    logic [HISTORY_BITS-1:0]             r_hist [NUM_KEYS];
    logic [HISTORY_BITS-1:0]             n_hist [NUM_KEYS];
    logic [COL_W-1:0]                    r_col;
    logic [COL_W-1:0]                    n_col;
    logic [kpsd_pkg::PATTERN_W-1:0]      r_press;
    logic [kpsd_pkg::PATTERN_W-1:0]      r_release;
    logic                                r_out_valid;
    logic [kpsd_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic [kpsd_pkg::OUT_TDATA_W-1:0]    n_out_data;

    logic                                s_accept;
    logic                                cfg_write;
    logic [ROWS_EXT_W-1:0]               rows_ext;
    logic [kpsd_pkg::COL_DRIVE_W-1:0]    col_drive;
    logic [PAT_EXT_W-1:0]                press_ext;
    logic [PAT_EXT_W-1:0]                release_ext;
    kpsd_pkg::t_match                    press_match;
    kpsd_pkg::t_match                    release_match;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign rows_ext        = ROWS_EXT_W'(i_s_axis_tdata[kpsd_pkg::ROW_BITS_W-1:0]);

    // Shift the sampled rows into the histories of the driven column
    always_comb begin
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                n_hist[c*NUM_ROWS + r] = r_hist[c*NUM_ROWS + r];
                if (s_accept && (32'(r_col) == c)) begin
                    n_hist[c*NUM_ROWS + r] =
                        {r_hist[c*NUM_ROWS + r][HISTORY_BITS-2:0], rows_ext[r]};
                end
            end
        end
    end

    always_comb begin
        if (32'(r_col) == NUM_COLUMNS - 1) begin
            n_col = '0;
        end else begin
            n_col = r_col + 1'b1;
        end
        // columns beyond the drive field show as no drive
        for (int i = 0; i < kpsd_pkg::COL_DRIVE_W; i++) begin
            col_drive[i] = (32'(n_col) == i);
        end
    end

    assign press_ext   = PAT_EXT_W'(r_press);
    assign release_ext = PAT_EXT_W'(r_release);

    kpsd_match #(
        .NUM_KEYS     (NUM_KEYS),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_press_match (
        .i_hist    (n_hist),
        .i_pattern (press_ext[HISTORY_BITS-1:0]),
        .o_match   (press_match)
    );

    kpsd_match #(
        .NUM_KEYS     (NUM_KEYS),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_release_match (
        .i_hist    (n_hist),
        .i_pattern (release_ext[HISTORY_BITS-1:0]),
        .o_match   (release_match)
    );

    assign n_out_data = {{PAD_W{1'b0}},
                         release_match.key, release_match.valid,
                         press_match.key, press_match.valid,
                         col_drive};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_hist[k] <= '0;
            end
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hist <= n_hist;
            if (s_accept) begin
                r_col       <= n_col;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // APB registers
    assign o_pready  = 1'b1;
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press   <= kpsd_pkg::PRESS_PATTERN_RST;
            r_release <= kpsd_pkg::RELEASE_PATTERN_RST;
        end else if (cfg_write) begin
            case (i_paddr[2])
                kpsd_pkg::REG_IDX_PRESS: begin
                    r_press <= i_pwdata[kpsd_pkg::PATTERN_W-1:0];
                end
                kpsd_pkg::REG_IDX_RELEASE: begin
                    r_release <= i_pwdata[kpsd_pkg::PATTERN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            kpsd_pkg::REG_IDX_PRESS:   o_prdata = kpsd_pkg::APB_DATA_W'(r_press);
            kpsd_pkg::REG_IDX_RELEASE: o_prdata = kpsd_pkg::APB_DATA_W'(r_release);
            default:                   o_prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < NUM_COLUMNS)
        else $error("column counter out of range");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> o_m_axis_tvalid)
        else $error("accepted tick produced no result");

    a_col_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_col != $past(r_col)))
        else $error("column did not advance on a tick");

    a_no_match_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[4] || (o_m_axis_tdata[8:5] == '0)) &&
             (o_m_axis_tdata[9] || (o_m_axis_tdata[13:10] == '0))))
        else $error("key reported without a match");

endmodule

`default_nettype wire

@@ tb/sv/keypad_scan_debounce_test.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_debounce_test
// Self-checking bench for the keypad scanner: drives row samples over the
// slave stream with random gaps and sink stalls, predicts each scan result
// (next column drive, lowest press / release key) and checks every transfer
// on the master stream, across several press / release pattern settings.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_debounce_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_KEYS    = kpsd_pkg::NUM_COLUMNS_DEF * kpsd_pkg::NUM_ROWS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    // Packed from the top bit down, so column_drive sits in the lowest bits
    typedef struct packed {
        logic [kpsd_pkg::KEY_W-1:0]       rel_key;
        logic                             rel_v;
        logic [kpsd_pkg::KEY_W-1:0]       press_key;
        logic                             press_v;
        logic [kpsd_pkg::COL_DRIVE_W-1:0] col_drive;
    } t_scan_result;

    // ------------------------------------------------------------------------
    // Scan predictor and result checker
    // ------------------------------------------------------------------------
    class keypad_scoreboard;
        logic [kpsd_pkg::HISTORY_BITS_DEF-1:0] history[NUM_KEYS];
        int unsigned                           column;
        logic [kpsd_pkg::PATTERN_W-1:0]        press_pat;
        logic [kpsd_pkg::PATTERN_W-1:0]        release_pat;
        t_scan_result                          expected_scans[$];
        int                                    errors;

        function new();
            foreach (history[k]) history[k] = '0;
            column      = 0;
            press_pat   = kpsd_pkg::PRESS_PATTERN_RST;
            release_pat = kpsd_pkg::RELEASE_PATTERN_RST;
            errors      = 0;
        endfunction

        function void set_pattern(logic idx, logic [kpsd_pkg::PATTERN_W-1:0] value);
            if (idx == kpsd_pkg::REG_IDX_PRESS)
                press_pat = value;
            else
                release_pat = value;
        endfunction

        function void find_key(logic [kpsd_pkg::PATTERN_W-1:0] pat, output logic hit,
                               output logic [kpsd_pkg::KEY_W-1:0] key);
            logic [kpsd_pkg::HISTORY_BITS_DEF-1:0] want;
            want = pat[kpsd_pkg::HISTORY_BITS_DEF-1:0];
            hit  = 1'b0;
            key  = '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (!hit && history[k] == want) begin
                    hit = 1'b1;
                    key = kpsd_pkg::KEY_W'(k);
                end
            end
        endfunction

        // One accepted scan tick: shift the column's rows in, move on, search
        function void note_tick(logic [kpsd_pkg::ROW_BITS_W-1:0] rows);
            t_scan_result res;
            int           idx;
            for (int r = 0; r < kpsd_pkg::NUM_ROWS_DEF; r++) begin
                idx          = column * kpsd_pkg::NUM_ROWS_DEF + r;
                history[idx] = {history[idx][kpsd_pkg::HISTORY_BITS_DEF-2:0], rows[r]};
            end
            column        = (column + 1) % kpsd_pkg::NUM_COLUMNS_DEF;
            res.col_drive = kpsd_pkg::COL_DRIVE_W'(1 << column);
            find_key(press_pat, res.press_v, res.press_key);
            find_key(release_pat, res.rel_v, res.rel_key);
            expected_scans.push_back(res);
        endfunction

        function void compare(string field, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [kpsd_pkg::OUT_TDATA_W-1:0] word);
            t_scan_result exp_r, act_r;
            act_r = word[kpsd_pkg::OUT_FIELDS_W-1:0];
            if (expected_scans.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual 0x%0h",
                         $time, word);
                errors++;
                return;
            end
            exp_r = expected_scans.pop_front();
            compare("column_drive", 8'(exp_r.col_drive), 8'(act_r.col_drive));
            compare("press_valid", 8'(exp_r.press_v), 8'(act_r.press_v));
            compare("press_key", 8'(exp_r.press_key), 8'(act_r.press_key));
            compare("release_valid", 8'(exp_r.rel_v), 8'(act_r.rel_v));
            compare("release_key", 8'(exp_r.rel_key), 8'(act_r.rel_key));
        endfunction

        function int pending();
            return expected_scans.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [kpsd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b1;
    logic [kpsd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata;
    logic                                i_psel = 1'b0;
    logic                                i_penable = 1'b0;
    logic                                i_pwrite = 1'b0;
    logic [kpsd_pkg::APB_ADDR_W-1:0]     i_paddr = '0;
    logic [kpsd_pkg::APB_DATA_W-1:0]     i_pwdata = '0;
    logic [kpsd_pkg::APB_DATA_W-1:0]     o_prdata;
    logic                                o_pready;

    keypad_scan_debounce DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    keypad_scoreboard sb = new();

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    int unsigned cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("keypad_scan_debounce_test: errors");
            $finish;
        end
    end

    // Transfers on both streams; input noted first so its result is predicted before it is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_tick(i_s_axis_tdata[kpsd_pkg::ROW_BITS_W-1:0]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata);
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Sink: random stalls, with calm stretches of always-ready
    int sink_hold = 0;
    int sink_calm = 0;
    always @(negedge i_clk) begin
        if (sink_calm > 0)
            sink_calm--;
        else if ($urandom_range(0, 199) == 0)
            sink_calm = $urandom_range(20, 80);
        if (sink_hold > 0) begin
            i_m_axis_tready = 1'b0;
            sink_hold--;
        end else begin
            i_m_axis_tready = 1'b1;
            if (sink_calm == 0 && $urandom_range(0, 99) < 30)
                sink_hold = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Drivers (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    int unsigned stim_column = 0;
    int          src_calm = 0;

    task automatic send_tick(logic [kpsd_pkg::ROW_BITS_W-1:0] rows);
        int gap;
        if (src_calm > 0) begin
            src_calm--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 99) == 0)
                src_calm = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = kpsd_pkg::IN_TDATA_W'(rows);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        stim_column = (stim_column + 1) % kpsd_pkg::NUM_COLUMNS_DEF;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic apb_write(logic idx, logic [kpsd_pkg::PATTERN_W-1:0] value);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = kpsd_pkg::APB_ADDR_W'({idx, 2'b00});
        // upper data bits are junk, only the low byte is kept
        i_pwdata  = {24'($urandom_range(0, 32'hffffff)), value};
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        sb.set_pattern(idx, value);
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    // Bouncy key model: held keys give steady rows, with the odd glitch
    bit keys_down[NUM_KEYS];

    task automatic run_keys(int count, int pause_at);
        logic [kpsd_pkg::ROW_BITS_W-1:0] rows;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at)
                drain();
            if ($urandom_range(0, 99) < 6)
                keys_down[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
            if ($urandom_range(0, 99) < 15) begin
                rows = kpsd_pkg::ROW_BITS_W'($urandom_range(0, 15));
            end else begin
                for (int r = 0; r < kpsd_pkg::NUM_ROWS_DEF; r++)
                    rows[r] = keys_down[stim_column * kpsd_pkg::NUM_ROWS_DEF + r];
                if ($urandom_range(0, 99) < 5)
                    rows[$urandom_range(0, kpsd_pkg::NUM_ROWS_DEF - 1)] ^= 1'b1;
            end
            send_tick(rows);
        end
    endtask

    task automatic new_patterns(logic [kpsd_pkg::PATTERN_W-1:0] press_v,
                                logic [kpsd_pkg::PATTERN_W-1:0] rel_v);
        drain();
        apb_write(kpsd_pkg::REG_IDX_PRESS, press_v);
        apb_write(kpsd_pkg::REG_IDX_RELEASE, rel_v);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    logic [kpsd_pkg::ROW_BITS_W-1:0] directed_rows[] = '{
        4'h0, 4'hf, 4'hf, 4'hf, 4'hf, 4'h1, 4'h2, 4'h4, 4'h8, 4'h5, 4'ha,
        4'h0, 4'h0, 4'h0, 4'h0, 4'hf, 4'hf, 4'hf, 4'hf, 4'h3, 4'hc, 4'h6,
        4'h9, 4'h0, 4'hf
    };

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        new_patterns(kpsd_pkg::PRESS_PATTERN_RST, kpsd_pkg::RELEASE_PATTERN_RST);
        foreach (directed_rows[n])
            send_tick(directed_rows[n]);

        // full debounce with the reset patterns; pause mid-way until drained
        run_keys(260, 130);
        new_patterns(8'h00, 8'hff);
        run_keys(200, -1);
        new_patterns(8'hff, 8'h00);
        run_keys(200, -1);
        new_patterns(8'h0f, 8'hf0);
        run_keys(240, -1);
        new_patterns(kpsd_pkg::PATTERN_W'($urandom_range(0, 255)),
                     kpsd_pkg::PATTERN_W'($urandom_range(0, 255)));
        run_keys(200, -1);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("keypad_scan_debounce_test: clean");
        else
            $display("keypad_scan_debounce_test: errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ keypad_scan_debounce.f @@
rtl/core/kpsd_pkg.sv
rtl/core/kpsd_match.sv
rtl/core/keypad_scan_debounce.sv
tb/sv/keypad_scan_debounce_test.sv
